@@ sv/rpb_pkg.sv @@
// shared constants and types for the rounded progress bar pixel generator
`default_nettype none

package rpb_pkg;

  // default width of the length register and column counter
  localparam int MAX_LENGTH_BITS_DEF = 10;

  // fixed field widths
  localparam int THICK_W    = 8;
  localparam int PROG_W     = 7;
  localparam int COLOR_W    = 16;
  localparam int RADIUS_W   = 7;
  localparam int DY_W       = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_LENGTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BAR_THICKNESS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PROGRESS      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR    = 2'd3;

  // register reset values
  localparam int BAR_LENGTH_RST = 100;
  localparam logic [THICK_W-1:0] BAR_THICKNESS_RST = 8'd16;
  localparam logic [PROG_W-1:0]  PROGRESS_RST      = 7'd0;
  localparam logic [COLOR_W-1:0] FILL_COLOR_RST    = 16'h0000;

  // colors
  localparam logic [COLOR_W-1:0] DARK_GREY = 16'h8631;
  localparam logic [COLOR_W-1:0] BLACK     = 16'h0000;

  // full scale of the progress value
  localparam int PCT_FULL = 100;

  // per-pixel flags handed from the geometry stage to the shading stage
  typedef struct packed {
    logic end_col;
    logic filled;
    logic last;
  } rpb_flags_t;

endpackage

`default_nettype wire

@@ sv/rounded_progress_bar_pixel_generator.sv @@
// rounded progress bar pixel generator: config registers, position stage and pipeline
// throughput: one pixel per cycle while out_ready holds, set by the three-register pipeline
//   (position register, geometry register, output register) with per-stage ready
// reset: synchronous active-low; position returns to row 0 column 0, pipeline empties,
//   registers return to length 100, thickness 16, progress 0, fill color black
`default_nettype none

module rounded_progress_bar_pixel_generator #(
  parameter int MAX_LENGTH_BITS = rpb_pkg::MAX_LENGTH_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic                            in_restart,
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic [rpb_pkg::COLOR_W-1:0]          out_pixel_color,
  output logic                                 out_last_pixel,
  input  wire logic                            cfg_wr_en,
  input  wire logic [rpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rpb_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import rpb_pkg::*;

  localparam int LW  = MAX_LENGTH_BITS;
  localparam int DXW = ((LW > 8) ? LW : 8) + 2;

  // configuration registers
  logic [LW-1:0]      bar_length_r;
  logic [THICK_W-1:0] bar_thickness_r;
  logic [PROG_W-1:0]  progress_r;
  logic [COLOR_W-1:0] fill_color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bar_length_r    <= LW'(BAR_LENGTH_RST);
      bar_thickness_r <= BAR_THICKNESS_RST;
      progress_r      <= PROGRESS_RST;
      fill_color_r    <= FILL_COLOR_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BAR_LENGTH:    bar_length_r    <= cfg_wdata[LW-1:0];
        CFG_BAR_THICKNESS: bar_thickness_r <= cfg_wdata[THICK_W-1:0];
        CFG_PROGRESS:      progress_r      <= cfg_wdata[PROG_W-1:0];
        CFG_FILL_COLOR:    fill_color_r    <= cfg_wdata[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // position counters
  logic               accept;
  logic [LW-1:0]      pos_col;
  logic [THICK_W-1:0] pos_row;
  logic               pos_last;

  assign accept = in_valid && in_ready;

  rpb_pos #(.LW(LW)) u_pos (
    .clk           (clk),
    .rst_n         (rst_n),
    .advance       (accept),
    .restart       (in_restart),
    .bar_length    (bar_length_r),
    .bar_thickness (bar_thickness_r),
    .col           (pos_col),
    .row           (pos_row),
    .last          (pos_last)
  );

  // position register
  logic               s1_valid_r;
  logic [LW-1:0]      s1_col_r;
  logic [THICK_W-1:0] s1_row_r;
  logic               s1_last_r;
  logic               geom_in_ready;

  assign in_ready = !s1_valid_r || geom_in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col_r  <= pos_col;
      s1_row_r  <= pos_row;
      s1_last_r <= pos_last;
    end
  end

  // geometry stage
  logic                   geom_valid;
  logic                   shade_in_ready;
  logic signed [DXW-1:0]  geom_dx;
  logic signed [DY_W-1:0] geom_dy;
  logic [RADIUS_W-1:0]    geom_radius;
  rpb_flags_t             geom_flags;

  rpb_geom #(.LW(LW), .DXW(DXW)) u_geom (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (s1_valid_r),
    .in_ready      (geom_in_ready),
    .col           (s1_col_r),
    .row           (s1_row_r),
    .last          (s1_last_r),
    .bar_length    (bar_length_r),
    .bar_thickness (bar_thickness_r),
    .progress      (progress_r),
    .out_valid     (geom_valid),
    .out_ready     (shade_in_ready),
    .dx            (geom_dx),
    .dy            (geom_dy),
    .radius        (geom_radius),
    .flags         (geom_flags)
  );

  // shading stage and output register
  rpb_shade #(.DXW(DXW)) u_shade (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (geom_valid),
    .in_ready    (shade_in_ready),
    .dx          (geom_dx),
    .dy          (geom_dy),
    .radius      (geom_radius),
    .flags       (geom_flags),
    .fill_color  (fill_color_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_color (out_pixel_color),
    .last_pixel  (out_last_pixel)
  );

  // a restart transaction enters the pipeline at the origin
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_restart |=> (s1_col_r == '0) && (s1_row_r == '0))
    else $error("restart transaction not at the origin");

  // the position register holds while the geometry stage stalls
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !geom_in_ready |=> s1_valid_r && $stable(s1_col_r) && $stable(s1_row_r))
    else $error("position register changed while stalled");

endmodule

`default_nettype wire

@@ sv/rpb_pos.sv @@
// raster position counters: column runs fastest, then row, with restart and wrap
`default_nettype none

module rpb_pos #(
  parameter int LW = rpb_pkg::MAX_LENGTH_BITS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        advance,
  input  wire logic                        restart,
  input  wire logic [LW-1:0]               bar_length,
  input  wire logic [rpb_pkg::THICK_W-1:0] bar_thickness,
  output logic      [LW-1:0]               col,
  output logic      [rpb_pkg::THICK_W-1:0] row,
  output logic                             last
);
  import rpb_pkg::*;

  logic [LW-1:0]      col_r, col_nxt;
  logic [THICK_W-1:0] row_r, row_nxt;
  logic [LW-1:0]      len_eff;
  logic [THICK_W-1:0] thk_eff;
  logic               end_of_row;

  // zero length or thickness wraps as one
  assign len_eff = (bar_length == '0) ? LW'(1) : bar_length;
  assign thk_eff = (bar_thickness == '0) ? THICK_W'(1) : bar_thickness;

  // current position, restart applied
  assign col = restart ? '0 : col_r;
  assign row = restart ? '0 : row_r;

  assign end_of_row = (col >= (len_eff - LW'(1)));
  assign last       = end_of_row && (row >= (thk_eff - THICK_W'(1)));

  // next position
  always_comb begin
    if (end_of_row) begin
      col_nxt = '0;
      row_nxt = last ? '0 : (row + THICK_W'(1));
    end else begin
      col_nxt = col + LW'(1);
      row_nxt = row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (advance) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // wrap to the origin after the final pixel
  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    advance && last |=> (col_r == '0) && (row_r == '0))
    else $error("position did not wrap after final pixel");

  // position holds without a transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(col_r) && $stable(row_r))
    else $error("position moved without a transaction");

endmodule

`default_nettype wire

@@ sv/rpb_geom.sv @@
// geometry stage: end-column test, arc offsets and filled-column compare
`default_nettype none

module rpb_geom #(
  parameter int LW  = rpb_pkg::MAX_LENGTH_BITS_DEF,
  parameter int DXW = ((LW > 8) ? LW : 8) + 2
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [LW-1:0]                col,
  input  wire logic [rpb_pkg::THICK_W-1:0]  row,
  input  wire logic                         last,
  input  wire logic [LW-1:0]                bar_length,
  input  wire logic [rpb_pkg::THICK_W-1:0]  bar_thickness,
  input  wire logic [rpb_pkg::PROG_W-1:0]   progress,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [DXW-1:0]             dx,
  output logic signed [rpb_pkg::DY_W-1:0]   dy,
  output logic [rpb_pkg::RADIUS_W-1:0]      radius,
  output rpb_pkg::rpb_flags_t               flags
);
  import rpb_pkg::*;

  localparam int FW = LW + PROG_W;

  logic [RADIUS_W-1:0]  rad;
  logic signed [DXW-1:0] col_s, rad_s, right_cx, cx, dx_nxt;
  logic signed [DY_W-1:0] dy_nxt;
  logic                 left_end, right_end;
  logic [LW:0]          col_p1;
  logic [FW-1:0]        lhs, rhs;
  rpb_flags_t           flags_nxt;

  logic                 valid_r;
  logic signed [DXW-1:0] dx_r;
  logic signed [DY_W-1:0] dy_r;
  logic [RADIUS_W-1:0]  rad_r;
  rpb_flags_t           flags_r;

  // arc centres and end-column test, signed so a wide radius covers every column
  assign rad      = bar_thickness[THICK_W-1:1];
  assign col_s    = $signed(DXW'(col));
  assign rad_s    = $signed(DXW'(rad));
  assign right_cx = $signed(DXW'(bar_length)) - rad_s;
  assign left_end  = (col_s < rad_s);
  assign right_end = (col_s > right_cx);
  assign cx        = left_end ? rad_s : right_cx;
  assign dx_nxt    = (left_end || right_end) ? (cx - col_s) : '0;
  assign dy_nxt    = $signed(DY_W'(rad)) - $signed(DY_W'(row));

  // col < floor(len*pct/100) is the same as 100*(col+1) <= len*pct
  assign col_p1 = (LW+1)'(col) + (LW+1)'(1);
  assign lhs    = FW'(col_p1) * FW'(PCT_FULL);
  assign rhs    = FW'(bar_length) * FW'(progress);

  always_comb begin
    flags_nxt.end_col = left_end || right_end;
    flags_nxt.filled  = (lhs <= rhs);
    flags_nxt.last    = last;
  end

  // stage register
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      rad_r   <= rad;
      flags_r <= flags_nxt;
    end
  end

  assign out_valid = valid_r;
  assign dx        = dx_r;
  assign dy        = dy_r;
  assign radius    = rad_r;
  assign flags     = flags_r;

  // off the ends the horizontal offset is unused and kept at zero
  a_dx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !flags_r.end_col |-> (dx_r == '0))
    else $error("nonzero offset outside the end columns");

endmodule

`default_nettype wire

@@ sv/rpb_shade.sv @@
// shading stage: squared distance against radius squared, color select, output register
`default_nettype none

module rpb_shade #(
  parameter int DXW = 12
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic signed [DXW-1:0]         dx,
  input  wire logic signed [rpb_pkg::DY_W-1:0] dy,
  input  wire logic [rpb_pkg::RADIUS_W-1:0]  radius,
  input  wire rpb_pkg::rpb_flags_t           flags,
  input  wire logic [rpb_pkg::COLOR_W-1:0]   fill_color,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rpb_pkg::COLOR_W-1:0]        pixel_color,
  output logic                               last_pixel
);
  import rpb_pkg::*;

  localparam int SW = 2 * DXW + 1;

  logic signed [2*DXW-1:0]  dx_sq;
  logic signed [2*DY_W-1:0] dy_sq;
  logic [2*RADIUS_W-1:0]    r_sq;
  logic [SW-1:0]            dist_sq;
  logic                     outside;
  logic [COLOR_W-1:0]       color_nxt;

  logic                     valid_r;
  logic [COLOR_W-1:0]       color_r;
  logic                     last_r;

  // squared distance from the arc centre
  assign dx_sq   = dx * dx;
  assign dy_sq   = dy * dy;
  assign r_sq    = radius * radius;
  assign dist_sq = SW'($unsigned(dx_sq)) + SW'($unsigned(dy_sq));
  assign outside = flags.end_col && (dist_sq > SW'(r_sq));

  // color select
  always_comb begin
    if (outside) begin
      color_nxt = BLACK;
    end else if (flags.filled) begin
      color_nxt = fill_color;
    end else begin
      color_nxt = DARK_GREY;
    end
  end

  // output register
  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      color_r <= color_nxt;
      last_r  <= flags.last;
    end
  end

  assign out_valid   = valid_r;
  assign pixel_color = color_r;
  assign last_pixel  = last_r;

  // a pixel is black, the fill color or dark grey
  a_color: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (color_r == BLACK) || (color_r == fill_color) || (color_r == DARK_GREY))
    else $error("pixel color outside the palette");

endmodule

`default_nettype wire

@@ test/rounded_progress_bar_checker.sv @@
// scoreboard that predicts and checks the progress bar pixel stream
module rounded_progress_bar_checker
  import rpb_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  input  wire logic                   in_ready,
  input  wire logic                   in_restart,
  input  wire logic                   out_valid,
  input  wire logic                   out_ready,
  input  wire logic [COLOR_W-1:0]     out_pixel_color,
  input  wire logic                   out_last_pixel,
  input  wire logic                   cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                          error_count,
  output int                          pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEN_W = MAX_LENGTH_BITS_DEF;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic               last;
  } bar_pixel_t;

  bar_pixel_t expected_pixels[$];

  // shadow copy of the bar registers and raster position
  logic [LEN_W-1:0]   bar_len;
  logic [THICK_W-1:0] bar_thick;
  logic [PROG_W-1:0]  bar_pct;
  logic [COLOR_W-1:0] bar_color;
  logic [LEN_W-1:0]   col_pos;
  logic [THICK_W-1:0] row_pos;
  int                 mismatches;

  // color of one raster position under the current registers
  function automatic logic [COLOR_W-1:0] shade_pixel(int col, int row);
    int radius, len, cx, dx, dy, filled;
    radius = int'(bar_thick) / 2;
    len    = int'(bar_len);
    filled = int'(bar_len) * int'(bar_pct) / PCT_FULL;
    // end columns: outside the arc is black
    if (col < radius || col > len - radius) begin
      cx = (col < radius) ? radius : len - radius;
      dx = cx - col;
      dy = radius - row;
      if (dx * dx + dy * dy > radius * radius) return BLACK;
    end
    if (col < filled) return bar_color;
    return DARK_GREY;
  endfunction

  always @(posedge clk) begin
    bar_pixel_t got, want;
    int len_eff, thk_eff;
    logic row_end;
    if (!rst_n) begin
      bar_len   = LEN_W'(BAR_LENGTH_RST);
      bar_thick = BAR_THICKNESS_RST;
      bar_pct   = PROGRESS_RST;
      bar_color = FILL_COLOR_RST;
      col_pos   = '0;
      row_pos   = '0;
      mismatches = 0;
      expected_pixels.delete();
    end else begin
      // result transaction against the oldest expectation
      if (out_valid && out_ready) begin
        got.color = out_pixel_color;
        got.last  = out_last_pixel;
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected pixel, actual color %h last %b",
                   $time, got.color, got.last);
          mismatches++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.color !== want.color) begin
            $display("%0t: pixel_color expected %h actual %h",
                     $time, want.color, got.color);
            mismatches++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last_pixel expected %b actual %b",
                     $time, want.last, got.last);
            mismatches++;
          end
        end
      end

      // register writes, masked to register width
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BAR_LENGTH:    bar_len   = cfg_wdata[LEN_W-1:0];
          CFG_BAR_THICKNESS: bar_thick = cfg_wdata[THICK_W-1:0];
          CFG_PROGRESS:      bar_pct   = cfg_wdata[PROG_W-1:0];
          CFG_FILL_COLOR:    bar_color = cfg_wdata[COLOR_W-1:0];
          default: ;
        endcase
      end

      // request transaction: predict the pixel and step the raster
      if (in_valid && in_ready) begin
        if (in_restart) begin
          col_pos = '0;
          row_pos = '0;
        end
        len_eff = (bar_len == 0) ? 1 : int'(bar_len);
        thk_eff = (bar_thick == 0) ? 1 : int'(bar_thick);
        row_end = int'(col_pos) >= len_eff - 1;
        want.color = shade_pixel(int'(col_pos), int'(row_pos));
        want.last  = row_end && (int'(row_pos) >= thk_eff - 1);
        expected_pixels.push_back(want);
        if (row_end) begin
          col_pos = '0;
          row_pos = want.last ? '0 : row_pos + 1'b1;
        end else begin
          col_pos = col_pos + 1'b1;
        end
      end
    end
    error_count   <= mismatches;
    pending_count <= expected_pixels.size();
  end

endmodule

@@ test/rounded_progress_bar_pixel_generator_test.sv @@
// stimulus, register programming and verdict for the progress bar pixel generator
module rounded_progress_bar_pixel_generator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rpb_pkg::*;

  localparam int LEN_W          = MAX_LENGTH_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_restart = 1'b0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [COLOR_W-1:0]    out_pixel_color;
  logic                  out_last_pixel;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_BAR_LENGTH;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  int                    error_count;
  int                    pending_count;

  int idle_cycles = 0;
  bit gap_on;
  int stall_left = 0;
  int stall_mode_left = 0;
  bit stall_on;

  rounded_progress_bar_pixel_generator u_top (.*);

  rounded_progress_bar_checker u_checker (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    return ($urandom_range(0, 9) != 0) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  // bar dimension: extremes now and then, mostly small so frames complete
  function automatic int pick_size(int top, int typical);
    case ($urandom_range(0, 15))
      0:       return 0;
      1:       return 1;
      2:       return top;
      3:       return $urandom_range(2, top);
      default: return $urandom_range(1, typical);
    endcase
  endfunction

  // receiver back-pressure in stretches, some with no stalls at all
  always @(posedge clk) begin
    if (stall_mode_left == 0) begin
      stall_mode_left = $urandom_range(50, 300);
      stall_on = ($urandom_range(0, 2) != 0);
    end
    stall_mode_left--;
    if (stall_left == 0 && stall_on && $urandom_range(0, 3) == 0)
      stall_left = pick_gap();
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one pixel request transaction, then maybe a gap
  task automatic send_pixel_request(input bit restart);
    int gap;
    if (!in_valid) in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    gap = (gap_on && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off requests until every pixel has come back
  task automatic drain_results();
    if (in_valid) in_valid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // single register write, sometimes with junk above the register width
  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int value, input int width);
    logic [CFG_DATA_W-1:0] data;
    data = CFG_DATA_W'(value);
    if (width < CFG_DATA_W && $urandom_range(0, 3) == 0)
      data = data | (CFG_DATA_W'($urandom) << width);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  // program the selected registers while the block is idle
  task automatic configure_bar(input bit [3:0] mask, input int len, input int thk,
                               input int pct, input int color);
    if (mask[0]) put_reg(CFG_BAR_LENGTH, len, LEN_W);
    if (mask[1]) put_reg(CFG_BAR_THICKNESS, thk, THICK_W);
    if (mask[2]) put_reg(CFG_PROGRESS, pct, PROG_W);
    if (mask[3]) put_reg(CFG_FILL_COLOR, color, COLOR_W);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int n, pct;
    gap_on = $urandom_range(0, 1);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset defaults: rounded left end, nothing filled
    repeat (3) send_pixel_request(1'b0);
    drain_results();

    // one-pixel bar with zero radius: every transaction ends the frame
    configure_bar(4'b1111, 1, 1, 100, 16'hFFFF);
    send_pixel_request(1'b0);
    send_pixel_request(1'b1);
    send_pixel_request(1'b0);
    drain_results();

    // zero length and thickness wrap as one
    configure_bar(4'b0011, 0, 0, 0, 0);
    send_pixel_request(1'b0);
    send_pixel_request(1'b0);
    send_pixel_request(1'b1);
    drain_results();

    // radius wider than the bar: every column is an end column
    configure_bar(4'b0111, 3, 255, 50, 0);
    repeat (4) send_pixel_request(1'b0);
    drain_results();

    // progress beyond full scale fills every in-arc pixel
    configure_bar(4'b1111, 5, 2, 127, 16'h5AA5);
    send_pixel_request(1'b1);
    repeat (3) send_pixel_request(1'b0);
    drain_results();

    // shrink mid-frame so the column sits past the new limit
    configure_bar(4'b0011, 2, 1, 0, 0);
    repeat (3) send_pixel_request(1'b0);
    drain_results();

    // random settings, mostly free-running frames with rare restarts
    for (int phase = 0; phase < 11; phase++) begin
      gap_on = ($urandom_range(0, 2) != 0);
      if (phase == 5) begin
        // long bar with the widest radius: run across the first row to reach the right arc
        configure_bar(4'b1111, 320, 255, $urandom_range(0, 100),
                      $urandom_range(0, 16'hFFFF));
        send_pixel_request(1'b1);
        repeat (330) send_pixel_request(1'b0);
      end else begin
        case ($urandom_range(0, 7))
          0:       pct = 0;
          1:       pct = PCT_FULL;
          2:       pct = $urandom_range(PCT_FULL + 1, (1 << PROG_W) - 1);
          default: pct = $urandom_range(0, PCT_FULL);
        endcase
        configure_bar(4'($urandom_range(1, 15)), pick_size((1 << LEN_W) - 1, 16),
                      pick_size(255, 10), pct, $urandom_range(0, 16'hFFFF));
        n = $urandom_range(30, 60);
        repeat (n) send_pixel_request($urandom_range(0, 24) == 0);
      end
      drain_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
